// ----- sv/pfpe_pkg.sv -----
package pfpe_pkg;

    localparam int WIDTH       = 128;
    localparam int HEIGHT      = 64;
    localparam int BYTE_W      = 8;
    localparam int PAGE_COUNT  = (HEIGHT + 7) / 8;
    localparam int STORE_BYTES = WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROW_W       = 9;
    localparam int PIX_W       = 13;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ADDR_W:0]   t_saddr;
    typedef logic [PAGE_W-1:0] t_page;
    typedef logic [PAGE_W:0]   t_srcq;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [PIX_W-1:0]  t_paddr;
    typedef logic [7:0]        t_col;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_READ   = 3'd2,
        OP_CLS    = 3'd3,
        OP_SCROLL = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX,
        S_CLR,
        S_SC_A,
        S_SC_B,
        S_SC_W
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] scroll_rows;
    } t_in_item;

    typedef struct packed {
        logic pixel_value;
        logic in_range;
    } t_out_item;

    typedef struct packed {
        logic [2:0] amount;
        t_row       row_base;
        t_row       limit;
        logic       lo_ok;
        logic       hi_ok;
    } t_shift_ctl;

endpackage

// ----- sv/page_framebuffer_pixel_engine_core.sv -----
// Channel | Ports                  | Handshake
// --------+------------------------+-----------------------------------------
// item in | i_item                 | taken at a clock edge with start && !busy
// result  | o_result               | valid for the one cycle o_done is high
//
// Set, clear, read and unused opcodes read one byte of the frame store; set
// and clear write it back if on-screen; the result shows in the next cycle.
// Clear screen and a full scroll sweep the store, one byte a cycle.
// A partial scroll does two reads and one write per byte of the store.
// After reset, a clearing pass over all STORE_BYTES bytes holds busy high.
// The receiver cannot stall; the block is busy while an item is in work.
module page_framebuffer_pixel_engine_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pfpe_pkg::t_in_item  i_item,
    output logic                o_done,
    output pfpe_pkg::t_out_item o_result
);

    pfpe_pkg::t_state     r_state;
    pfpe_pkg::t_state     n_state;
    pfpe_pkg::t_in_item   r_item;
    pfpe_pkg::t_addr      r_paddr;
    pfpe_pkg::t_addr      r_cnt;
    logic                 r_boot;
    pfpe_pkg::t_col       r_col;
    pfpe_pkg::t_page      r_page;
    pfpe_pkg::t_addr      r_dst;
    pfpe_pkg::t_saddr     r_src;
    pfpe_pkg::t_srcq      r_srcq;
    pfpe_pkg::t_row       r_row;
    pfpe_pkg::t_byte      r_lo;
    logic                 r_done;
    pfpe_pkg::t_out_item  r_result;
    logic                 n_done;
    pfpe_pkg::t_out_item  n_result;

    logic                 we;
    pfpe_pkg::t_addr      waddr;
    pfpe_pkg::t_byte      wdata;
    pfpe_pkg::t_addr      raddr;
    pfpe_pkg::t_byte      rdata;
    pfpe_pkg::t_byte      shift_out;
    pfpe_pkg::t_shift_ctl shift_ctl;
    pfpe_pkg::t_paddr     pix_addr_in;
    pfpe_pkg::t_byte      pix_mask;
    logic                 in_rng;
    logic                 last_col;
    logic                 last_byte;

    assign pix_addr_in = pfpe_pkg::t_paddr'(i_item.x_pos)
        + pfpe_pkg::t_paddr'(i_item.y_pos[7:3]) * pfpe_pkg::t_paddr'(pfpe_pkg::WIDTH);
    assign in_rng = ({1'b0, r_item.x_pos} < 9'(pfpe_pkg::WIDTH))
        && ({1'b0, r_item.y_pos} < 9'(pfpe_pkg::HEIGHT));
    assign pix_mask  = pfpe_pkg::t_byte'(1) << r_item.y_pos[2:0];
    assign last_col  = (r_col == pfpe_pkg::t_col'(pfpe_pkg::WIDTH - 1));
    assign last_byte = last_col && (r_page == pfpe_pkg::t_page'(pfpe_pkg::PAGE_COUNT - 1));

    assign shift_ctl.amount   = r_item.scroll_rows[2:0];
    assign shift_ctl.row_base = r_row;
    assign shift_ctl.limit    = pfpe_pkg::t_row'(pfpe_pkg::HEIGHT)
        - pfpe_pkg::t_row'(r_item.scroll_rows);
    assign shift_ctl.lo_ok    = r_srcq < pfpe_pkg::t_srcq'(pfpe_pkg::PAGE_COUNT);
    assign shift_ctl.hi_ok    = r_srcq < pfpe_pkg::t_srcq'(pfpe_pkg::PAGE_COUNT - 1);

    pfpe_ram #(
        .DATA_W(pfpe_pkg::BYTE_W),
        .DEPTH (pfpe_pkg::STORE_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    pfpe_shift u_shift (
        .i_lo  (r_lo),
        .i_hi  (rdata),
        .i_ctl (shift_ctl),
        .o_byte(shift_out)
    );

    assign busy     = (r_state != pfpe_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        raddr    = '0;
        unique case (r_state)
            pfpe_pkg::S_IDLE: begin
                raddr = pfpe_pkg::t_addr'(pix_addr_in);
                if (start) begin
                    case (pfpe_pkg::t_opcode'(i_item.opcode))
                        pfpe_pkg::OP_CLS: begin
                            n_state = pfpe_pkg::S_CLR;
                        end
                        pfpe_pkg::OP_SCROLL: begin
                            if (i_item.scroll_rows == '0) begin
                                n_state = pfpe_pkg::S_PIX;
                            end else if ({1'b0, i_item.scroll_rows}
                                         >= 9'(pfpe_pkg::HEIGHT)) begin
                                n_state = pfpe_pkg::S_CLR;
                            end else begin
                                n_state = pfpe_pkg::S_SC_A;
                            end
                        end
                        default: begin
                            n_state = pfpe_pkg::S_PIX;
                        end
                    endcase
                end
            end
            pfpe_pkg::S_PIX: begin
                n_state = pfpe_pkg::S_IDLE;
                n_done  = 1'b1;
                case (pfpe_pkg::t_opcode'(r_item.opcode))
                    pfpe_pkg::OP_SET: begin
                        we                = in_rng;
                        waddr             = r_paddr;
                        wdata             = rdata | pix_mask;
                        n_result.in_range = in_rng;
                    end
                    pfpe_pkg::OP_CLEAR: begin
                        we                = in_rng;
                        waddr             = r_paddr;
                        wdata             = rdata & ~pix_mask;
                        n_result.in_range = in_rng;
                    end
                    pfpe_pkg::OP_READ: begin
                        n_result.in_range    = in_rng;
                        n_result.pixel_value = in_rng && rdata[r_item.y_pos[2:0]];
                    end
                    default: begin
                        n_result = '0;
                    end
                endcase
            end
            pfpe_pkg::S_CLR: begin
                we    = 1'b1;
                waddr = r_cnt;
                if (r_cnt == pfpe_pkg::t_addr'(pfpe_pkg::STORE_BYTES - 1)) begin
                    n_state = pfpe_pkg::S_IDLE;
                    n_done  = !r_boot;
                end
            end
            pfpe_pkg::S_SC_A: begin
                raddr   = pfpe_pkg::t_addr'(r_src + pfpe_pkg::t_saddr'(r_col));
                n_state = pfpe_pkg::S_SC_B;
            end
            pfpe_pkg::S_SC_B: begin
                raddr   = pfpe_pkg::t_addr'(r_src + pfpe_pkg::t_saddr'(pfpe_pkg::WIDTH)
                    + pfpe_pkg::t_saddr'(r_col));
                n_state = pfpe_pkg::S_SC_W;
            end
            pfpe_pkg::S_SC_W: begin
                we    = 1'b1;
                waddr = pfpe_pkg::t_addr'(r_dst + pfpe_pkg::t_addr'(r_col));
                wdata = shift_out;
                if (last_byte) begin
                    n_state = pfpe_pkg::S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = pfpe_pkg::S_SC_A;
                end
            end
            default: begin
                n_state = pfpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfpe_pkg::S_CLR;
            r_cnt   <= '0;
            r_boot  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == pfpe_pkg::S_CLR) begin
                r_cnt <= r_cnt + pfpe_pkg::t_addr'(1);
                if (n_state == pfpe_pkg::S_IDLE) begin
                    r_boot <= 1'b0;
                end
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            r_result <= n_result;
        end
        if (r_state == pfpe_pkg::S_SC_B) begin
            r_lo <= rdata;
        end
        if (r_state == pfpe_pkg::S_IDLE) begin
            r_item  <= i_item;
            r_paddr <= pfpe_pkg::t_addr'(pix_addr_in);
            r_col   <= '0;
            r_page  <= '0;
            r_dst   <= '0;
            r_row   <= '0;
            r_srcq  <= pfpe_pkg::t_srcq'(i_item.scroll_rows[7:3]);
            r_src   <= pfpe_pkg::t_saddr'(pfpe_pkg::t_paddr'(i_item.scroll_rows[7:3])
                * pfpe_pkg::t_paddr'(pfpe_pkg::WIDTH));
        end else if (r_state == pfpe_pkg::S_SC_W) begin
            if (last_col) begin
                r_col  <= '0;
                r_page <= r_page + pfpe_pkg::t_page'(1);
                r_dst  <= r_dst + pfpe_pkg::t_addr'(pfpe_pkg::WIDTH);
                r_src  <= r_src + pfpe_pkg::t_saddr'(pfpe_pkg::WIDTH);
                r_srcq <= r_srcq + pfpe_pkg::t_srcq'(1);
                r_row  <= r_row + pfpe_pkg::t_row'(pfpe_pkg::BYTE_W);
            end else begin
                r_col <= r_col + pfpe_pkg::t_col'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state != pfpe_pkg::S_IDLE))
        else $error("result strobe without preceding work");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == pfpe_pkg::S_PIX || r_state == pfpe_pkg::S_CLR
                || r_state == pfpe_pkg::S_SC_W))
        else $error("store written outside a write state");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.pixel_value) |-> o_result.in_range)
        else $error("pixel value reported for coordinates outside the display");
`endif

endmodule

// ----- sv/pfpe_ram.sv -----
module pfpe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/pfpe_shift.sv -----
module pfpe_shift (
    input  pfpe_pkg::t_byte      i_lo,
    input  pfpe_pkg::t_byte      i_hi,
    input  pfpe_pkg::t_shift_ctl i_ctl,
    output pfpe_pkg::t_byte      o_byte
);

    pfpe_pkg::t_byte lo_v;
    pfpe_pkg::t_byte hi_v;
    logic [15:0]     word;

    // Rows at or beyond the scroll limit are blanked.
    always_comb begin
        lo_v = i_ctl.lo_ok ? i_lo : '0;
        hi_v = i_ctl.hi_ok ? i_hi : '0;
        word = {hi_v, lo_v} >> i_ctl.amount;
        for (int b = 0; b < pfpe_pkg::BYTE_W; b++) begin
            o_byte[b] = word[b]
                & ((i_ctl.row_base + pfpe_pkg::t_row'(b)) < i_ctl.limit);
        end
    end

endmodule

// ----- test/page_framebuffer_pixel_engine_core_test.sv -----
`timescale 1ns / 100ps

module page_framebuffer_pixel_engine_core_test;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_GAP_MAX = 40;
    localparam int TAIL_CYCLES  = 8;
    localparam int STALL_LIMIT  = 4 * (3 * pfpe_pkg::STORE_BYTES + LONG_GAP_MAX + 16);

    // Shadow copy of the frame store plus the results still owed by the block.
    class frame_shadow;
        pfpe_pkg::t_byte     frame [pfpe_pkg::STORE_BYTES];
        pfpe_pkg::t_out_item owed_results [$];
        int                  failures;
        int                  lit_reads;
        int                  off_screen;
        int                  scrolls;
        int                  wipes;

        function new();
            wipe();
            failures   = 0;
            lit_reads  = 0;
            off_screen = 0;
            scrolls    = 0;
            wipes      = 0;
        endfunction

        function void wipe();
            foreach (frame[i]) frame[i] = '0;
        endfunction

        function bit on_screen(int x, int y);
            return (x < pfpe_pkg::WIDTH) && (y < pfpe_pkg::HEIGHT);
        endfunction

        function logic pixel_at(int x, int y);
            return frame[x + (y / 8) * pfpe_pkg::WIDTH][y % 8];
        endfunction

        function void put_pixel(int x, int y, logic v);
            frame[x + (y / 8) * pfpe_pkg::WIDTH][y % 8] = v;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void note_command(pfpe_pkg::t_in_item it);
            int                  x;
            int                  y;
            int                  rows;
            pfpe_pkg::t_out_item res;
            x    = int'(it.x_pos);
            y    = int'(it.y_pos);
            rows = int'(it.scroll_rows);
            res  = '0;
            case (it.opcode) inside
                pfpe_pkg::OP_SET, pfpe_pkg::OP_CLEAR, pfpe_pkg::OP_READ: begin
                    res.in_range = on_screen(x, y);
                    if (!res.in_range) begin
                        off_screen++;
                    end else if (it.opcode == pfpe_pkg::OP_SET) begin
                        put_pixel(x, y, 1'b1);
                    end else if (it.opcode == pfpe_pkg::OP_CLEAR) begin
                        put_pixel(x, y, 1'b0);
                    end else begin
                        res.pixel_value = pixel_at(x, y);
                        if (res.pixel_value) lit_reads++;
                    end
                end
                pfpe_pkg::OP_CLS: begin
                    wipe();
                    wipes++;
                end
                pfpe_pkg::OP_SCROLL: begin
                    scrolls++;
                    if (rows >= pfpe_pkg::HEIGHT) begin
                        wipe();
                    end else if (rows > 0) begin
                        for (int row = 0; row < pfpe_pkg::HEIGHT; row++) begin
                            for (int col = 0; col < pfpe_pkg::WIDTH; col++) begin
                                if (row < pfpe_pkg::HEIGHT - rows) begin
                                    put_pixel(col, row, pixel_at(col, row + rows));
                                end else begin
                                    put_pixel(col, row, 1'b0);
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            owed_results.push_back(res);
        endfunction

        function void check_result(pfpe_pkg::t_out_item got);
            pfpe_pkg::t_out_item want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: pixel_value=%0b in_range=%0b",
                       got.pixel_value, got.in_range);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.pixel_value !== want.pixel_value) begin
                $error("pixel_value: expected %0b, actual %0b",
                       want.pixel_value, got.pixel_value);
                failures++;
            end
            if (got.in_range !== want.in_range) begin
                $error("in_range: expected %0b, actual %0b", want.in_range, got.in_range);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    pfpe_pkg::t_in_item  i_item  = '0;
    logic                o_done;
    pfpe_pkg::t_out_item o_result;
    frame_shadow         shadow  = new();
    int                  idle_cycles = 0;
    int                  items_sent  = 0;

    page_framebuffer_pixel_engine_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) shadow.check_result(o_result);
            if (start && !busy) shadow.note_command(i_item);
            if (o_done || (start && !busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $error("no item or result for %0d cycles", idle_cycles);
                $display("FAIL page_framebuffer_pixel_engine_core");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic pfpe_pkg::t_in_item make_cmd(logic [2:0] op, int x, int y, int rows);
        pfpe_pkg::t_in_item it;
        it.opcode      = op;
        it.x_pos       = 8'(x);
        it.y_pos       = 8'(y);
        it.scroll_rows = 8'(rows);
        return it;
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, LONG_GAP_MAX);
    endfunction

    function automatic pfpe_pkg::t_in_item random_cmd();
        pfpe_pkg::t_in_item it;
        int                 r;
        int                 spot;
        r    = $urandom_range(0, 999);
        spot = $urandom_range(0, 99);
        it.scroll_rows = 8'($urandom_range(0, 255));
        if (spot < 60) begin
            it.x_pos = 8'($urandom_range(0, 15));
            it.y_pos = 8'($urandom_range(0, pfpe_pkg::HEIGHT - 1));
        end else if (spot < 85) begin
            it.x_pos = 8'($urandom_range(0, pfpe_pkg::WIDTH - 1));
            it.y_pos = 8'($urandom_range(0, pfpe_pkg::HEIGHT - 1));
        end else begin
            it.x_pos = 8'($urandom_range(0, 255));
            it.y_pos = 8'($urandom_range(0, 255));
        end
        if (r < 380) begin
            it.opcode = pfpe_pkg::OP_SET;
        end else if (r < 500) begin
            it.opcode = pfpe_pkg::OP_CLEAR;
        end else if (r < 920) begin
            it.opcode = pfpe_pkg::OP_READ;
        end else if (r < 925) begin
            it.opcode = pfpe_pkg::OP_CLS;
        end else if (r < 965) begin
            it.opcode = pfpe_pkg::OP_SCROLL;
            spot = $urandom_range(0, 99);
            if (spot < 70) begin
                it.scroll_rows = 8'($urandom_range(1, 7));
            end else if (spot < 85) begin
                it.scroll_rows = 8'($urandom_range(8, pfpe_pkg::HEIGHT - 1));
            end else if (spot < 90) begin
                it.scroll_rows = '0;
            end else begin
                it.scroll_rows = 8'($urandom_range(pfpe_pkg::HEIGHT, 255));
            end
        end else begin
            it.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return it;
    endfunction

    task automatic send_cmd(pfpe_pkg::t_in_item it, int gap);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= make_cmd(3'($urandom), int'($urandom), int'($urandom),
                               int'($urandom));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    initial begin
        bit burst;
        burst = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(make_cmd(pfpe_pkg::OP_READ, 0, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, 0, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, pfpe_pkg::WIDTH - 1, pfpe_pkg::HEIGHT - 1, 0),
                 pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, pfpe_pkg::WIDTH - 1, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, 0, pfpe_pkg::HEIGHT - 1, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, pfpe_pkg::WIDTH - 1, pfpe_pkg::HEIGHT - 1, 0),
                 pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, pfpe_pkg::WIDTH, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, 255, 255, 255), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, 0, pfpe_pkg::HEIGHT, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_CLEAR, 0, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, 0, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(OP_SPARE_FIRST, 255, 255, 255), pick_gap(1'b0));
        send_cmd(make_cmd(OP_SPARE_LAST, 255, 255, 255), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SCROLL, 255, 255, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, pfpe_pkg::WIDTH - 1, pfpe_pkg::HEIGHT - 1, 0),
                 pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, 5, 9, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SCROLL, 0, 0, 1), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, 5, 8, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, pfpe_pkg::WIDTH - 1, pfpe_pkg::HEIGHT - 2, 0),
                 pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SET, 3, pfpe_pkg::HEIGHT - 1, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SCROLL, 0, 0, pfpe_pkg::HEIGHT - 1), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, 3, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SCROLL, 0, 0, pfpe_pkg::HEIGHT), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_READ, 3, 0, 0), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_SCROLL, 0, 0, 255), pick_gap(1'b0));
        send_cmd(make_cmd(pfpe_pkg::OP_CLS, 255, 255, 255), pick_gap(1'b0));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n % 350 == 175) drain();
            send_cmd(random_cmd(), pick_gap(burst));
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, %0d of them off-screen pixel commands; %0d reads hit a lit pixel.",
                 items_sent, shadow.off_screen, shadow.lit_reads);
        $display("Covered %0d scrolls and %0d screen clears, with %0d mismatches.",
                 shadow.scrolls, shadow.wipes, shadow.failures);
        if (shadow.failures == 0) begin
            $display("PASS page_framebuffer_pixel_engine_core");
        end else begin
            $display("FAIL page_framebuffer_pixel_engine_core");
        end
        $finish;
    end

endmodule
